/* hw/rtl/shag_pkg.sv */
// ----------------------------------------------------------------------------
// shag_pkg
// Types and constants shared by the sensor health and arm gate block.
// ----------------------------------------------------------------------------
package shag_pkg;

	// One update tick as it arrives on the input channel.
	typedef struct packed {
		logic [31:0] time_ms;
		logic        imu_good;
		logic        mag_good;
		logic        baro_good;
		logic        fusion_good;
		logic        calibrated_flag;
		logic        radio_link_good;
		logic [15:0] throttle_us;
		logic [15:0] arm_switch_us;
		logic        optical_needed;
		logic        optical_good;
		logic [7:0]  arm_state;
	} tick_t;

	// One status word as it leaves on the output channel.
	typedef struct packed {
		logic [4:0]  fault_bits;
		logic        instant_good;
		logic        sensors_good;
		logic        preflight_ok;
		logic [2:0]  block_reason;
		logic [31:0] drop_total;
		logic        buzzer_on;
	} status_t;

	// Configuration register set.
	typedef struct packed {
		logic [3:0]  good_streak_limit;
		logic [3:0]  fail_streak_limit;
		logic [15:0] throttle_arm_max;
		logic [15:0] arm_switch_min;
		logic [15:0] beep_phase_ms;
	} cfg_t;

	localparam int unsigned CFG_INDEX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS  = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_GOOD_LIMIT   = 3'd0,
		CFG_FAIL_LIMIT   = 3'd1,
		CFG_THROTTLE_MAX = 3'd2,
		CFG_SWITCH_MIN   = 3'd3,
		CFG_BEEP_PHASE   = 3'd4
	} cfg_index_t;

	localparam logic [3:0]  RST_GOOD_LIMIT   = 4'd3;
	localparam logic [3:0]  RST_FAIL_LIMIT   = 4'd3;
	localparam logic [15:0] RST_THROTTLE_MAX = 16'd1150;
	localparam logic [15:0] RST_SWITCH_MIN   = 16'd1500;
	localparam logic [15:0] RST_BEEP_PHASE   = 16'd100;

	typedef enum logic [2:0] {
		REASON_READY    = 3'd0,
		REASON_SENSORS  = 3'd1,
		REASON_THROTTLE = 3'd2,
		REASON_SWITCH   = 3'd3,
		REASON_LINK     = 3'd4,
		REASON_OPTICAL  = 3'd5
	} block_reason_t;

	// A beep is one on phase followed by one off phase.
	localparam logic [1:0] BEEP_PHASES = 2'd2;

endpackage

/* hw/rtl/shag_if.sv */
// ----------------------------------------------------------------------------
// shag_if
// Valid/ready channels carrying update ticks in and status words out.
// ----------------------------------------------------------------------------
interface shag_tick_if
	import shag_pkg::*;
();
	logic  valid;
	logic  ready;
	tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

interface shag_status_if
	import shag_pkg::*;
();
	logic    valid;
	logic    ready;
	status_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

/* hw/rtl/shag_cfg.sv */
// ----------------------------------------------------------------------------
// shag_cfg
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module shag_cfg
	import shag_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.good_streak_limit <= RST_GOOD_LIMIT;
			cfg_q.fail_streak_limit <= RST_FAIL_LIMIT;
			cfg_q.throttle_arm_max  <= RST_THROTTLE_MAX;
			cfg_q.arm_switch_min    <= RST_SWITCH_MIN;
			cfg_q.beep_phase_ms     <= RST_BEEP_PHASE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GOOD_LIMIT:   cfg_q.good_streak_limit <= cfg_data[3:0];
				CFG_FAIL_LIMIT:   cfg_q.fail_streak_limit <= cfg_data[3:0];
				CFG_THROTTLE_MAX: cfg_q.throttle_arm_max  <= cfg_data;
				CFG_SWITCH_MIN:   cfg_q.arm_switch_min    <= cfg_data;
				CFG_BEEP_PHASE:   cfg_q.beep_phase_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/shag_core.sv */
// ----------------------------------------------------------------------------
// shag_core
// Health debounce, arm gating and beep sequencer state for one tick.
// ----------------------------------------------------------------------------
module shag_core
	import shag_pkg::*;
#(
	parameter int unsigned TIME_BITS  = 32,
	parameter int unsigned PULSE_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  tick_t   item,
	input  logic    fire,
	output status_t result
);

	logic [3:0]           good_run_q;
	logic [3:0]           fail_run_q;
	logic                 healthy_q;
	logic [31:0]          drop_q;
	logic [7:0]           prev_arm_q;
	logic [TIME_BITS-1:0] phase_start_q;
	logic [1:0]           phases_left_q;
	logic                 buzz_q;

	logic [3:0]           good_run_d;
	logic [3:0]           fail_run_d;
	logic                 healthy_d;
	logic [31:0]          drop_d;
	logic [TIME_BITS-1:0] phase_start_d;
	logic [1:0]           phases_left_d;
	logic                 buzz_d;

	logic [4:0]           faults;
	logic                 ok;
	logic [3:0]           good_inc;
	logic [3:0]           fail_inc;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] elapsed;
	logic [PULSE_BITS-1:0] throttle;
	logic [PULSE_BITS-1:0] arm_sw;
	logic                 arm_change;
	logic                 preflight;
	block_reason_t        reason;

	assign now      = TIME_BITS'(item.time_ms);
	assign throttle = PULSE_BITS'(item.throttle_us);
	assign arm_sw   = PULSE_BITS'(item.arm_switch_us);

	assign faults = ~{item.calibrated_flag, item.fusion_good, item.baro_good,
		item.mag_good, item.imu_good};
	assign ok = (faults == 5'd0);

	// The runs stop at their limit, so the increment never wraps.
	assign good_inc = (good_run_q < cfg.good_streak_limit) ? good_run_q + 4'd1 : good_run_q;
	assign fail_inc = (fail_run_q < cfg.fail_streak_limit) ? fail_run_q + 4'd1 : fail_run_q;

	always_comb begin
		good_run_d = good_run_q;
		fail_run_d = fail_run_q;
		healthy_d  = healthy_q;
		drop_d     = drop_q;
		if (ok) begin
			fail_run_d = 4'd0;
			good_run_d = good_inc;
			if (good_inc >= cfg.good_streak_limit) begin
				healthy_d = 1'b1;
			end
		end else begin
			good_run_d = 4'd0;
			fail_run_d = fail_inc;
			if (fail_inc >= cfg.fail_streak_limit) begin
				healthy_d = 1'b0;
				drop_d    = drop_q + 32'(healthy_q);
			end
		end
	end

	assign preflight = healthy_d && item.radio_link_good && item.calibrated_flag
		&& item.fusion_good;

	always_comb begin
		if (!healthy_d) begin
			reason = REASON_SENSORS;
		end else if (!item.radio_link_good) begin
			reason = REASON_LINK;
		end else if (16'(throttle) >= cfg.throttle_arm_max) begin
			reason = REASON_THROTTLE;
		end else if (16'(arm_sw) <= cfg.arm_switch_min) begin
			reason = REASON_SWITCH;
		end else if (item.optical_needed && !item.optical_good) begin
			reason = REASON_OPTICAL;
		end else begin
			reason = REASON_READY;
		end
	end

	// A new arm code restarts the sequence with the buzzer on; the phase that
	// has just started may end on the same tick if the phase length is zero.
	assign arm_change = (item.arm_state != prev_arm_q);
	assign elapsed    = now - phase_start_q;

	always_comb begin
		phase_start_d = phase_start_q;
		phases_left_d = phases_left_q;
		buzz_d        = buzz_q;
		if (arm_change) begin
			phase_start_d = now;
			phases_left_d = BEEP_PHASES;
			buzz_d        = 1'b1;
			if (cfg.beep_phase_ms == 16'd0) begin
				phases_left_d = BEEP_PHASES - 2'd1;
				buzz_d        = 1'b0;
			end
		end else if (phases_left_q != 2'd0) begin
			if (elapsed >= TIME_BITS'(cfg.beep_phase_ms)) begin
				phase_start_d = now;
				phases_left_d = phases_left_q - 2'd1;
				buzz_d        = (phases_left_q == 2'd1) ? 1'b0 : !buzz_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_run_q    <= '0;
			fail_run_q    <= '0;
			healthy_q     <= 1'b0;
			drop_q        <= '0;
			prev_arm_q    <= '0;
			phase_start_q <= '0;
			phases_left_q <= '0;
			buzz_q        <= 1'b0;
		end else if (fire) begin
			good_run_q    <= good_run_d;
			fail_run_q    <= fail_run_d;
			healthy_q     <= healthy_d;
			drop_q        <= drop_d;
			prev_arm_q    <= item.arm_state;
			phase_start_q <= phase_start_d;
			phases_left_q <= phases_left_d;
			buzz_q        <= buzz_d;
		end
	end

	always_comb begin
		result.fault_bits   = faults;
		result.instant_good = ok;
		result.sensors_good = healthy_d;
		result.preflight_ok = preflight;
		result.block_reason = reason;
		result.drop_total   = drop_d;
		result.buzzer_on    = buzz_d;
	end

endmodule

/* hw/rtl/sensor_health_arm_gate.sv */
// ----------------------------------------------------------------------------
// sensor_health_arm_gate
// Per-tick sensor health debounce, arm gating and arm-change beep sequencer.
// ----------------------------------------------------------------------------
// The block takes one update tick per clock cycle while the status output is
// not stalled and returns exactly one status word per tick, in order. A tick
// in the input register is evaluated against the stored health and buzzer
// state, and its status word moves to the output register once that register
// is empty or its word is being collected. While a finished status word waits
// to be collected, a new tick is taken only if the input register is empty.
// Configuration writes are taken at any time but should only be made while
// no tick is in flight.
// ----------------------------------------------------------------------------
module sensor_health_arm_gate
	import shag_pkg::*;
#(
	parameter int unsigned TIME_BITS  = 32,
	parameter int unsigned PULSE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	shag_tick_if.sink                 tick,
	shag_status_if.source             status
);

	cfg_t    cfg;
	tick_t   item_s1;
	logic    valid_s1;
	status_t result;
	status_t status_q;
	logic    status_valid_q;
	logic    advance;
	logic    fire;

	shag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	shag_core #(
		.TIME_BITS  (TIME_BITS),
		.PULSE_BITS (PULSE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.result (result)
	);

	assign advance    = !status_valid_q || status.ready;
	assign fire       = valid_s1 && advance;
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			status_valid_q <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (advance) begin
				status_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1 <= tick.data;
		end
		if (fire) begin
			status_q <= result;
		end
	end

	assign status.valid = status_valid_q;
	assign status.data  = status_q;

endmodule

/* hw/rtl/shag_checker.sv */
// ----------------------------------------------------------------------------
// shag_checker
// Port-level checks on the status channel of the arm gate.
// ----------------------------------------------------------------------------
module shag_checker
	import shag_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    status_valid,
	input logic    status_ready,
	input status_t status_data
);

	// A stalled status word must stay put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid && $stable(status_data))
		else $error("status word changed while stalled");

	a_instant: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> status_data.instant_good == (status_data.fault_bits == 5'd0))
		else $error("instant_good disagrees with fault_bits");

	a_preflight: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status_data.preflight_ok |-> status_data.sensors_good)
		else $error("preflight_ok without debounced health");

	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> status_data.sensors_good
			== (status_data.block_reason != REASON_SENSORS))
		else $error("block reason disagrees with sensor health");

	// Between two consecutive delivered words the drop count moves by one at most.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status_ready ##1 status_valid |->
			status_data.drop_total == $past(status_data.drop_total)
			|| status_data.drop_total == $past(status_data.drop_total) + 32'd1)
		else $error("drop count jumped");

endmodule

bind sensor_health_arm_gate shag_checker u_shag_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.status_valid (status.valid),
	.status_ready (status.ready),
	.status_data  (status.data)
);
